>>> src/rv32_subset_decode_execute_defines.svh
// ----------------------------------------------------------------------------
// rv32_subset_decode_execute_defines
// Assertion macros used by the checker file of the decode/execute block.
// ----------------------------------------------------------------------------
`ifndef RV32_SUBSET_DECODE_EXECUTE_DEFINES_SVH
`define RV32_SUBSET_DECODE_EXECUTE_DEFINES_SVH

// plain property, sampled on clk_i, off during reset
`define RSDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// same-cycle implication
`define RSDE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication with a fixed latency
`define RSDE_ASSERT_LAT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##3 (cons)) \
    else $error(msg);

`endif

>>> src/rsde_pkg.sv
// ----------------------------------------------------------------------------
// rsde_pkg
// Opcodes, ALU codes and the control word of the RV32I subset decode/execute.
// ----------------------------------------------------------------------------
package rsde_pkg;

  localparam logic [6:0] OpcR     = 7'b0110011;
  localparam logic [6:0] OpcI     = 7'b0010011;
  localparam logic [6:0] OpcLui   = 7'b0110111;
  localparam logic [6:0] OpcLoad  = 7'b0000011;
  localparam logic [6:0] OpcStore = 7'b0100011;
  localparam logic [6:0] OpcJal   = 7'b1101111;
  localparam logic [6:0] OpcBeq   = 7'b1100011;

  localparam logic [2:0] F3Add = 3'd0;
  localparam logic [2:0] F3Xor = 3'd4;
  localparam logic [2:0] F3Sra = 3'd5;
  localparam logic [2:0] F3Or  = 3'd6;

  typedef enum logic [3:0] {
    AluAnd  = 4'd0,
    AluOr   = 4'd1,
    AluAdd  = 4'd2,
    AluXor  = 4'd3,
    AluSra  = 4'd4,
    AluSub  = 4'd6,
    AluPass = 4'd8,
    AluZero = 4'd15
  } alu_op_e;

  typedef enum logic [1:0] {
    ClsMem    = 2'd0,
    ClsBranch = 2'd1,
    ClsArith  = 2'd2,
    ClsJump   = 2'd3
  } alu_class_e;

  typedef struct packed {
    logic       reg_write;
    logic       alu_src;
    logic       branch;
    logic       mem_read;
    logic       mem_write;
    logic       mem_to_reg;
    alu_class_e alu_class;
    alu_op_e    alu_control;
    logic       supported;
  } ctrl_t;

endpackage

>>> src/rsde_decode.sv
// ----------------------------------------------------------------------------
// rsde_decode
// Stage 1: opcode decode, ALU code and immediate generation, registered.
// ----------------------------------------------------------------------------
module rsde_decode
  import rsde_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic        [31:0] instruction_i,
  input  logic signed [31:0] rs1_value_i,
  input  logic signed [31:0] rs2_value_i,
  output logic               valid_o,
  output ctrl_t              ctrl_o,
  output logic        [31:0] imm_o,
  output logic        [31:0] a_o,
  output logic        [31:0] b_o
);

  logic        valid_q;
  ctrl_t       ctrl_d, ctrl_q;
  logic [31:0] imm_d, imm_q, a_q, b_q;
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [31:0] ins;

  assign ins = instruction_i;
  assign opc = ins[6:0];
  assign f3  = ins[14:12];

  always_comb begin
    ctrl_d             = '0;
    ctrl_d.alu_class   = ClsMem;
    ctrl_d.alu_control = AluAnd;
    imm_d              = '0;
    case (opc)
      OpcR: begin
        ctrl_d.reg_write = 1'b1;
        ctrl_d.alu_class = ClsArith;
        ctrl_d.supported = 1'b1;
      end
      OpcI: begin
        ctrl_d.reg_write = 1'b1;
        ctrl_d.alu_src   = 1'b1;
        ctrl_d.alu_class = ClsArith;
        ctrl_d.supported = 1'b1;
        if (f3 == F3Sra) begin
          imm_d = {27'd0, ins[24:20]};
        end else begin
          imm_d = {{20{ins[31]}}, ins[31:20]};
        end
      end
      OpcLui: begin
        ctrl_d.reg_write = 1'b1;
        ctrl_d.alu_src   = 1'b1;
        ctrl_d.alu_class = ClsArith;
        ctrl_d.supported = 1'b1;
        imm_d            = {ins[31:12], 12'd0};
      end
      OpcLoad: begin
        ctrl_d.reg_write  = 1'b1;
        ctrl_d.alu_src    = 1'b1;
        ctrl_d.mem_read   = 1'b1;
        ctrl_d.mem_to_reg = 1'b1;
        ctrl_d.alu_class  = ClsMem;
        ctrl_d.supported  = 1'b1;
        imm_d             = {{20{ins[31]}}, ins[31:20]};
      end
      OpcStore: begin
        ctrl_d.alu_src   = 1'b1;
        ctrl_d.mem_write = 1'b1;
        ctrl_d.alu_class = ClsMem;
        ctrl_d.supported = 1'b1;
        imm_d            = {{20{ins[31]}}, ins[31:25], ins[11:7]};
      end
      OpcJal: begin
        ctrl_d.reg_write = 1'b1;
        ctrl_d.branch    = 1'b1;
        ctrl_d.alu_class = ClsJump;
        ctrl_d.supported = 1'b1;
        imm_d            = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
      end
      OpcBeq: begin
        ctrl_d.branch    = 1'b1;
        ctrl_d.alu_class = ClsBranch;
        ctrl_d.supported = 1'b1;
        imm_d            = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
      end
      default: begin
        ctrl_d.supported = 1'b0;
      end
    endcase

    if (ctrl_d.supported) begin
      case (ctrl_d.alu_class)
        ClsArith: begin
          if (opc == OpcLui) begin
            ctrl_d.alu_control = AluPass;
          end else begin
            case (f3)
              F3Add:   ctrl_d.alu_control = AluAdd;
              F3Xor:   ctrl_d.alu_control = AluXor;
              F3Or:    ctrl_d.alu_control = AluOr;
              F3Sra:   ctrl_d.alu_control = AluSra;
              default: ctrl_d.alu_control = AluZero;
            endcase
          end
        end
        ClsMem:    ctrl_d.alu_control = AluAdd;
        ClsBranch: ctrl_d.alu_control = AluSub;
        default:   ctrl_d.alu_control = AluZero;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      ctrl_q <= ctrl_d;
      imm_q  <= imm_d;
      a_q    <= rs1_value_i;
      b_q    <= rs2_value_i;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign imm_o   = imm_q;
  assign a_o     = a_q;
  assign b_o     = b_q;

endmodule

>>> src/rsde_alu.sv
// ----------------------------------------------------------------------------
// rsde_alu
// Stage 2 selects the second operand; stage 3 computes and holds the result.
// ----------------------------------------------------------------------------
module rsde_alu
  import rsde_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  ctrl_t       ctrl_i,
  input  logic [31:0] imm_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        valid_o,
  output ctrl_t       ctrl_o,
  output logic [31:0] imm_o,
  output logic [31:0] result_o
);

  // stage 2
  logic        s2_valid_q;
  ctrl_t       s2_ctrl_q;
  logic [31:0] s2_imm_q, s2_a_q, s2_op2_d, s2_op2_q;
  // stage 3
  logic        s3_valid_q;
  ctrl_t       s3_ctrl_q;
  logic [31:0] s3_imm_q, s3_res_d, s3_res_q;

  assign s2_op2_d = ctrl_i.alu_src ? imm_i : b_i;

  always_comb begin
    case (s2_ctrl_q.alu_control)
      AluAdd:  s3_res_d = s2_a_q + s2_op2_q;
      AluSub:  s3_res_d = s2_a_q - s2_op2_q;
      AluAnd:  s3_res_d = s2_a_q & s2_op2_q;
      AluOr:   s3_res_d = s2_a_q | s2_op2_q;
      AluXor:  s3_res_d = s2_a_q ^ s2_op2_q;
      AluSra:  s3_res_d = 32'($signed(s2_a_q) >>> s2_op2_q[4:0]);
      AluPass: s3_res_d = s2_op2_q;
      default: s3_res_d = '0;
    endcase
    if (!s2_ctrl_q.supported) begin
      s3_res_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= valid_i;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      s2_ctrl_q <= ctrl_i;
      s2_imm_q  <= imm_i;
      s2_a_q    <= a_i;
      s2_op2_q  <= s2_op2_d;
    end
    if (s2_valid_q) begin
      s3_ctrl_q <= s2_ctrl_q;
      s3_imm_q  <= s2_imm_q;
      s3_res_q  <= s3_res_d;
    end
  end

  assign valid_o  = s3_valid_q;
  assign ctrl_o   = s3_ctrl_q;
  assign imm_o    = s3_imm_q;
  assign result_o = s3_res_q;

endmodule

>>> src/rv32_subset_decode_execute.sv
// ----------------------------------------------------------------------------
// rv32_subset_decode_execute
// RV32I subset decode, immediate generation and ALU in a three-stage pipeline.
// ----------------------------------------------------------------------------
// channel   handshake            word
// -------   ------------------   ---------------------------------------------
// input     start_i && !busy_o   instruction_i, rs1_value_i, rs2_value_i
// result    done_o (one cycle)   reg_write_o .. alu_out_o, supported_o
//
// One word may enter every cycle; done_o is the registered valid of the ALU
// stage, and the result is taken while done_o is high.
// Latency is set by the decode, operand-select and ALU register stages.
// busy_o is held low: the pipeline never stalls and the receiver takes every
// result in its strobe cycle.
// rst_ni clears the valid bits of all stages; payload registers are not reset.
// ----------------------------------------------------------------------------
module rv32_subset_decode_execute
  import rsde_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic        [31:0] instruction_i,
  input  logic signed [31:0] rs1_value_i,
  input  logic signed [31:0] rs2_value_i,
  output logic               done_o,
  output logic               reg_write_o,
  output logic               alu_src_o,
  output logic               branch_o,
  output logic               mem_read_o,
  output logic               mem_write_o,
  output logic               mem_to_reg_o,
  output logic        [1:0]  alu_class_o,
  output logic        [3:0]  alu_control_o,
  output logic signed [31:0] immediate_o,
  output logic signed [31:0] alu_out_o,
  output logic               supported_o
);

  logic        dec_valid;
  ctrl_t       dec_ctrl;
  logic [31:0] dec_imm, dec_a, dec_b;
  ctrl_t       out_ctrl;
  logic [31:0] out_imm, out_res;

  assign busy_o = 1'b0;

  rsde_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (start_i && !busy_o),
    .instruction_i (instruction_i),
    .rs1_value_i   (rs1_value_i),
    .rs2_value_i   (rs2_value_i),
    .valid_o       (dec_valid),
    .ctrl_o        (dec_ctrl),
    .imm_o         (dec_imm),
    .a_o           (dec_a),
    .b_o           (dec_b)
  );

  rsde_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (dec_valid),
    .ctrl_i   (dec_ctrl),
    .imm_i    (dec_imm),
    .a_i      (dec_a),
    .b_i      (dec_b),
    .valid_o  (done_o),
    .ctrl_o   (out_ctrl),
    .imm_o    (out_imm),
    .result_o (out_res)
  );

  assign reg_write_o   = out_ctrl.reg_write;
  assign alu_src_o     = out_ctrl.alu_src;
  assign branch_o      = out_ctrl.branch;
  assign mem_read_o    = out_ctrl.mem_read;
  assign mem_write_o   = out_ctrl.mem_write;
  assign mem_to_reg_o  = out_ctrl.mem_to_reg;
  assign alu_class_o   = out_ctrl.alu_class;
  assign alu_control_o = out_ctrl.alu_control;
  assign supported_o   = out_ctrl.supported;
  assign immediate_o   = $signed(out_imm);
  assign alu_out_o     = $signed(out_res);

endmodule

>>> src/rsde_checker.sv
// ----------------------------------------------------------------------------
// rsde_checker
// Port-level checks of the decode/execute block, bound to the top level.
// ----------------------------------------------------------------------------
`include "rv32_subset_decode_execute_defines.svh"

module rsde_checker
  import rsde_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic               reg_write_o,
  input logic               alu_src_o,
  input logic               branch_o,
  input logic               mem_read_o,
  input logic               mem_write_o,
  input logic               mem_to_reg_o,
  input logic        [1:0]  alu_class_o,
  input logic        [3:0]  alu_control_o,
  input logic signed [31:0] immediate_o,
  input logic signed [31:0] alu_out_o,
  input logic               supported_o
);

  logic unsup_zero;
  logic load_ok;

  assign unsup_zero = (alu_out_o == '0) && !reg_write_o && !branch_o &&
                      (immediate_o == '0) && (alu_control_o == '0);
  assign load_ok    = mem_to_reg_o && reg_write_o && alu_src_o && !mem_write_o &&
                      (alu_class_o == ClsMem);

  `RSDE_ASSERT(a_never_busy, !busy_o, "pipeline reported busy")

  `RSDE_ASSERT_LAT(a_latency, start_i && !busy_o, done_o, "accepted word gave no result")

  `RSDE_ASSERT_IMP(a_no_spurious, done_o, $past(start_i, 3) && !$past(busy_o, 3), "stray result")

  `RSDE_ASSERT_IMP(a_unsup_zero, done_o && !supported_o, unsup_zero, "unknown opcode not zeroed")

  `RSDE_ASSERT_IMP(a_load_ctrl, done_o && mem_read_o, load_ok, "load controls inconsistent")

endmodule

bind rv32_subset_decode_execute rsde_checker u_rsde_checker (.*);
